FILE: sv/apdu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the command APDU parser.
// No dependencies; used by every module of the block.
package apdu_pkg;

    localparam int FRAME_CNT_W = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam logic [15:0] EXT_DATA_MAX_RST = 16'd1024;

    localparam logic [1:0] PS_OK        = 2'd0;
    localparam logic [1:0] PS_SHORT     = 2'd1;
    localparam logic [1:0] PS_BAD_LEN   = 2'd2;
    localparam logic [1:0] PS_LC_LARGE  = 2'd3;

    localparam logic [15:0] SW_OK        = 16'h9000;
    localparam logic [15:0] SW_WRONG_LEN = 16'h6700;

    localparam logic [2:0] CASE_NONE = 3'd0;
    localparam logic [2:0] CASE_1    = 3'd1;
    localparam logic [2:0] CASE_2    = 3'd2;
    localparam logic [2:0] CASE_3    = 3'd3;
    localparam logic [2:0] CASE_4    = 3'd4;

    localparam logic [2:0] CC_OK       = 3'd0;
    localparam logic [2:0] CC_CHANNEL  = 3'd1;
    localparam logic [2:0] CC_SECURE   = 3'd2;
    localparam logic [2:0] CC_CHAINING = 3'd3;
    localparam logic [2:0] CC_INVALID  = 3'd4;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       frame_last;
    } apdu_in_t;

    typedef struct packed {
        logic [1:0]  parse_status;
        logic [15:0] status_word;
        logic [2:0]  command_case;
        logic        is_extended;
        logic [7:0]  class_byte;
        logic [7:0]  instruction;
        logic [7:0]  param1;
        logic [7:0]  param2;
        logic [15:0] data_length;
        logic        expect_present;
        logic [16:0] expect_length;
        logic [2:0]  class_check;
    } apdu_out_t;

    // Snapshot of one finished frame, handed from front to back.
    typedef struct packed {
        logic [31:0]            header_bytes;
        logic [23:0]            length_bytes;
        logic [15:0]            recent_bytes;
        logic [FRAME_CNT_W-1:0] frame_count;
        logic                   over;
    } apdu_frame_t;

    typedef struct packed {
        logic full;
        logic empty;
    } apdu_q_stat_t;

endpackage

FILE: sv/apdu_front.sv
`timescale 1ns / 1ps
// Front end: accepts frame bytes, counts them and captures header and length bytes.
// Depends on apdu_pkg.
module apdu_front #(
    parameter int MAX_FRAME_LEN = 65535
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  apdu_pkg::apdu_in_t   in_word,
    input  apdu_pkg::apdu_q_stat_t q_stat,
    output logic                 push,
    output apdu_pkg::apdu_frame_t push_frame
);

    localparam int CNT_W = $clog2(MAX_FRAME_LEN + 2);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      header_reg, header_next;
    logic [23:0]      length_reg, length_next;
    logic [15:0]      recent_reg, recent_next;
    logic             accept;
    logic [1:0]       hidx;
    logic [1:0]       lidx;

    assign in_stall = q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = accept && in_word.frame_last;
    assign hidx     = 2'd3 - count_reg[1:0];
    assign lidx     = 2'd2 - count_reg[1:0];

    always_comb
    begin
        count_next  = count_reg;
        header_next = header_reg;
        length_next = length_reg;
        recent_next = recent_reg;
        if (accept)
        begin
            if (count_reg < CNT_W'(4))
            begin
                header_next[{hidx, 3'b000} +: 8] = in_word.byte_in;
            end
            else if (count_reg < CNT_W'(7))
            begin
                length_next[{lidx, 3'b000} +: 8] = in_word.byte_in;
            end
            recent_next = {recent_reg[7:0], in_word.byte_in};
            if (count_reg <= CNT_W'(MAX_FRAME_LEN))
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        push_frame.header_bytes = header_next;
        push_frame.length_bytes = length_next;
        push_frame.recent_bytes = recent_next;
        push_frame.frame_count  = apdu_pkg::FRAME_CNT_W'(count_next);
        push_frame.over         = count_next > CNT_W'(MAX_FRAME_LEN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            header_reg <= '0;
            length_reg <= '0;
            recent_reg <= '0;
        end
        else if (push)
        begin
            count_reg  <= '0;
            header_reg <= '0;
            length_reg <= '0;
            recent_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            header_reg <= header_next;
            length_reg <= length_next;
            recent_reg <= recent_next;
        end
    end

endmodule

FILE: sv/apdu_queue.sv
`timescale 1ns / 1ps
// Short queue of finished frame snapshots between front and back.
// Depends on apdu_pkg.
module apdu_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  apdu_pkg::apdu_frame_t  push_frame,
    input  logic                   pop,
    output apdu_pkg::apdu_frame_t  head_frame,
    output apdu_pkg::apdu_q_stat_t q_stat
);

    localparam int PTR_W = $clog2(apdu_pkg::QUEUE_DEPTH);

    apdu_pkg::apdu_frame_t entry_reg [apdu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   fill_reg, fill_next;
    logic             do_push, do_pop;

    assign q_stat.full  = fill_reg == (PTR_W + 1)'(apdu_pkg::QUEUE_DEPTH);
    assign q_stat.empty = fill_reg == '0;
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_frame   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

endmodule

FILE: sv/apdu_back.sv
`timescale 1ns / 1ps
// Back end: classifies a finished frame, decodes Lc/Le, checks CLA, holds the result word.
// Depends on apdu_pkg.
module apdu_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data,
    input  apdu_pkg::apdu_frame_t  head_frame,
    input  apdu_pkg::apdu_q_stat_t q_stat,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_stall,
    output apdu_pkg::apdu_out_t    out_word
);

    localparam int NW = apdu_pkg::FRAME_CNT_W;

    logic [15:0]         ext_max_reg;
    logic                out_valid_reg;
    apdu_pkg::apdu_out_t out_reg, out_next;

    logic [NW-1:0] n;
    logic [7:0]    p3;
    logic [15:0]   w56;
    logic [7:0]    lb;
    logic [15:0]   lw;
    logic [7:0]    cla;
    logic [1:0]    st;
    logic [2:0]    acase;
    logic          ext;
    logic [15:0]   lc;
    logic          lep;
    logic [16:0]   le;
    logic          over;

    function automatic logic [2:0] cla_check(input logic [7:0] c);
        logic [2:0] r;
        begin
            if (c == 8'hFF || (c & 8'hE0) != 8'h00)
                r = apdu_pkg::CC_INVALID;
            else if ((c & 8'h10) != 8'h00)
                r = apdu_pkg::CC_CHAINING;
            else if ((c & 8'h0C) != 8'h00)
                r = apdu_pkg::CC_SECURE;
            else if ((c & 8'h03) != 8'h00)
                r = apdu_pkg::CC_CHANNEL;
            else
                r = apdu_pkg::CC_OK;
            return r;
        end
    endfunction

    assign cfg_ready = 1'b1;
    assign pop       = !q_stat.empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

    always_comb
    begin
        n     = head_frame.frame_count;
        over  = head_frame.over;
        p3    = head_frame.length_bytes[23:16];
        w56   = head_frame.length_bytes[15:0];
        lb    = head_frame.recent_bytes[7:0];
        lw    = head_frame.recent_bytes;
        cla   = head_frame.header_bytes[31:24];
        st    = apdu_pkg::PS_OK;
        acase = apdu_pkg::CASE_NONE;
        ext   = 1'b0;
        lc    = '0;
        lep   = 1'b0;
        le    = '0;
        if (n < NW'(4))
        begin
            st = apdu_pkg::PS_SHORT;
        end
        else if (n == NW'(4))
        begin
            acase = apdu_pkg::CASE_1;
        end
        else if (n == NW'(5))
        begin
            acase = apdu_pkg::CASE_2;
            lep   = 1'b1;
            le    = (p3 == 8'd0) ? 17'd256 : 17'(p3);
        end
        else if (p3 != 8'd0)
        begin
            if (!over && n == NW'(p3) + NW'(5))
            begin
                acase = apdu_pkg::CASE_3;
                lc    = 16'(p3);
            end
            else if (!over && n == NW'(p3) + NW'(6))
            begin
                acase = apdu_pkg::CASE_4;
                lc    = 16'(p3);
                lep   = 1'b1;
                le    = (lb == 8'd0) ? 17'd256 : 17'(lb);
            end
            else
            begin
                st = apdu_pkg::PS_BAD_LEN;
            end
        end
        else if (n == NW'(6))
        begin
            st = apdu_pkg::PS_BAD_LEN;
        end
        else if (n == NW'(7))
        begin
            acase = apdu_pkg::CASE_2;
            ext   = 1'b1;
            lep   = 1'b1;
            le    = (w56 == 16'd0) ? 17'd65536 : 17'(w56);
        end
        else if (w56 == 16'd0)
        begin
            st = apdu_pkg::PS_BAD_LEN;
        end
        else if (w56 > ext_max_reg)
        begin
            st = apdu_pkg::PS_LC_LARGE;
        end
        else if (!over && n == NW'(w56) + NW'(7))
        begin
            acase = apdu_pkg::CASE_3;
            ext   = 1'b1;
            lc    = w56;
        end
        else if (!over && n == NW'(w56) + NW'(9))
        begin
            acase = apdu_pkg::CASE_4;
            ext   = 1'b1;
            lc    = w56;
            lep   = 1'b1;
            le    = (lw == 16'd0) ? 17'd65536 : 17'(lw);
        end
        else
        begin
            st = apdu_pkg::PS_BAD_LEN;
        end

        out_next              = '0;
        out_next.parse_status = st;
        out_next.status_word  = (st == apdu_pkg::PS_OK) ? apdu_pkg::SW_OK
                                                        : apdu_pkg::SW_WRONG_LEN;
        if (st == apdu_pkg::PS_OK)
        begin
            out_next.command_case   = acase;
            out_next.is_extended    = ext;
            out_next.class_byte     = cla;
            out_next.instruction    = head_frame.header_bytes[23:16];
            out_next.param1         = head_frame.header_bytes[15:8];
            out_next.param2         = head_frame.header_bytes[7:0];
            out_next.data_length    = lc;
            out_next.expect_present = lep;
            out_next.expect_length  = le;
            out_next.class_check    = cla_check(cla);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_max_reg   <= apdu_pkg::EXT_DATA_MAX_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                ext_max_reg <= cfg_data;
            end
            if (pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/command_apdu_parser.sv
`timescale 1ns / 1ps
// Top level of the command APDU parser: front end, frame queue and back end.
// Depends on apdu_pkg, apdu_front, apdu_queue, apdu_back.
//
// Takes one command APDU byte per cycle while in_stall is low, flagged
// frame_last on the final byte, and returns one result word per frame: parse
// status, status word, ISO case, decoded Lc and Le, the header bytes and a CLA
// check. A byte is taken in each cycle in which in_stall is low; the front end
// only counts and captures, and on the last byte hands a frame snapshot to a
// two-entry queue. The back end classifies the queue head combinationally into
// its output register. in_stall rises only when the queue is full, which
// happens only if out_stall holds back results. cfg_data sets the largest
// extended Lc accepted (reset 1024); write it while no frame is in progress.
module command_apdu_parser #(
    parameter int MAX_FRAME_LEN = 65535
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  apdu_pkg::apdu_in_t  in_word,
    output logic                out_valid,
    input  logic                out_stall,
    output apdu_pkg::apdu_out_t out_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data
);

    logic                   push;
    logic                   pop;
    apdu_pkg::apdu_frame_t  push_frame;
    apdu_pkg::apdu_frame_t  head_frame;
    apdu_pkg::apdu_q_stat_t q_stat;

    apdu_front #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .q_stat     (q_stat),
        .push       (push),
        .push_frame (push_frame)
    );

    apdu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .head_frame (head_frame),
        .q_stat     (q_stat)
    );

    apdu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .head_frame (head_frame),
        .q_stat     (q_stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for command_apdu_parser: directed and random command frames, each word
// checked against a behavioral frame decoder kept in a scoreboard class.
// Depends on apdu_pkg and the command_apdu_parser RTL.
module testbench;

    localparam int MAX_FRAME_LEN = 65535;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_BYTES = 225;
    localparam logic [7:0] CLA_SAMPLES [12] = '{8'h00, 8'h01, 8'h03, 8'h04, 8'h08, 8'h0C,
                                                8'h10, 8'h1F, 8'h20, 8'h80, 8'hE0, 8'hFF};

    typedef logic [7:0] byte_q_t[$];

    class apdu_scoreboard;
        int                  data_limit;
        int                  frame_len;
        logic [31:0]         header_bytes;
        logic [23:0]         length_bytes;
        logic [15:0]         recent_bytes;
        apdu_pkg::apdu_out_t frame_results[$];
        int                  failures;

        function new();
            data_limit = int'(apdu_pkg::EXT_DATA_MAX_RST);
            failures = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            frame_len = 0;
            header_bytes = '0;
            length_bytes = '0;
            recent_bytes = '0;
        endfunction

        function logic [2:0] cla_status(logic [7:0] c);
            if (c == 8'hFF || (c & 8'hE0) != 0) return apdu_pkg::CC_INVALID;
            if ((c & 8'h10) != 0) return apdu_pkg::CC_CHAINING;
            if ((c & 8'h0C) != 0) return apdu_pkg::CC_SECURE;
            if ((c & 8'h03) != 0) return apdu_pkg::CC_CHANNEL;
            return apdu_pkg::CC_OK;
        endfunction

        function apdu_pkg::apdu_out_t decode_frame(int n);
            apdu_pkg::apdu_out_t r;
            bit                  over;
            int                  p3;
            int                  w56;
            int                  lc;
            int                  le;
            logic [1:0]          st;
            logic [2:0]          acase;
            bit                  ext;
            bit                  lep;
            r = '0;
            over = n > MAX_FRAME_LEN;
            p3 = int'(length_bytes[23:16]);
            w56 = int'(length_bytes[15:0]);
            st = apdu_pkg::PS_OK;
            acase = apdu_pkg::CASE_NONE;
            ext = 0;
            lep = 0;
            lc = 0;
            le = 0;
            if (n < 4) st = apdu_pkg::PS_SHORT;
            else if (n == 4) acase = apdu_pkg::CASE_1;
            else if (n == 5)
            begin
                acase = apdu_pkg::CASE_2;
                lep = 1;
                le = (p3 == 0) ? 256 : p3;
            end
            else if (p3 != 0)
            begin
                if (!over && n == 5 + p3)
                begin
                    acase = apdu_pkg::CASE_3;
                    lc = p3;
                end
                else if (!over && n == 6 + p3)
                begin
                    acase = apdu_pkg::CASE_4;
                    lc = p3;
                    lep = 1;
                    le = (recent_bytes[7:0] == 0) ? 256 : int'(recent_bytes[7:0]);
                end
                else st = apdu_pkg::PS_BAD_LEN;
            end
            else if (n == 6) st = apdu_pkg::PS_BAD_LEN;
            else if (n == 7)
            begin
                acase = apdu_pkg::CASE_2;
                ext = 1;
                lep = 1;
                le = (w56 == 0) ? 65536 : w56;
            end
            else if (w56 == 0) st = apdu_pkg::PS_BAD_LEN;
            else if (w56 > data_limit) st = apdu_pkg::PS_LC_LARGE;
            else if (!over && n == 7 + w56)
            begin
                acase = apdu_pkg::CASE_3;
                ext = 1;
                lc = w56;
            end
            else if (!over && n == 9 + w56)
            begin
                acase = apdu_pkg::CASE_4;
                ext = 1;
                lc = w56;
                lep = 1;
                le = (recent_bytes == 0) ? 65536 : int'(recent_bytes);
            end
            else st = apdu_pkg::PS_BAD_LEN;
            r.parse_status = st;
            r.status_word = (st == apdu_pkg::PS_OK) ? apdu_pkg::SW_OK
                                                    : apdu_pkg::SW_WRONG_LEN;
            if (st == apdu_pkg::PS_OK)
            begin
                r.command_case = acase;
                r.is_extended = ext;
                r.class_byte = header_bytes[31:24];
                r.instruction = header_bytes[23:16];
                r.param1 = header_bytes[15:8];
                r.param2 = header_bytes[7:0];
                r.data_length = 16'(lc);
                r.expect_present = lep;
                r.expect_length = 17'(le);
                r.class_check = cla_status(header_bytes[31:24]);
            end
            return r;
        endfunction

        function void note_byte(apdu_pkg::apdu_in_t w);
            if (frame_len < 4) header_bytes[8 * (3 - frame_len) +: 8] = w.byte_in;
            else if (frame_len < 7) length_bytes[8 * (6 - frame_len) +: 8] = w.byte_in;
            recent_bytes = {recent_bytes[7:0], w.byte_in};
            if (frame_len <= MAX_FRAME_LEN) frame_len++;
            if (w.frame_last)
            begin
                frame_results.push_back(decode_frame(frame_len));
                clear_frame();
            end
        endfunction

        function void compare_field(string name, logic [16:0] want, logic [16:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(apdu_pkg::apdu_out_t got);
            apdu_pkg::apdu_out_t want;
            if (frame_results.size() == 0)
            begin
                $error("result word with no frame pending");
                failures++;
                return;
            end
            want = frame_results.pop_front();
            compare_field("parse_status", want.parse_status, got.parse_status);
            compare_field("status_word", want.status_word, got.status_word);
            compare_field("command_case", want.command_case, got.command_case);
            compare_field("is_extended", want.is_extended, got.is_extended);
            compare_field("class_byte", want.class_byte, got.class_byte);
            compare_field("instruction", want.instruction, got.instruction);
            compare_field("param1", want.param1, got.param1);
            compare_field("param2", want.param2, got.param2);
            compare_field("data_length", want.data_length, got.data_length);
            compare_field("expect_present", want.expect_present, got.expect_present);
            compare_field("expect_length", want.expect_length, got.expect_length);
            compare_field("class_check", want.class_check, got.class_check);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    apdu_pkg::apdu_in_t  in_word = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    apdu_pkg::apdu_out_t out_word;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [15:0]         cfg_data = '0;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    apdu_scoreboard sb = new();

    command_apdu_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall) sb.note_byte(in_word);
            if (out_valid && !out_stall) sb.check_result(out_word);
            if (cfg_valid && cfg_ready) sb.data_limit = int'(cfg_data);
        end
    end

    task automatic send_byte(logic [7:0] b, logic last);
        apdu_pkg::apdu_in_t w;
        w.byte_in = b;
        w.frame_last = last;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_frame(byte_q_t f);
        foreach (f[i]) send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.frame_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] le_byte();
        return ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    function automatic byte_q_t header4();
        byte_q_t q;
        q.push_back($urandom_range(1) ? CLA_SAMPLES[$urandom_range(11)] : 8'($urandom));
        repeat (3) q.push_back(8'($urandom));
        return q;
    endfunction

    // kinds: 0..6 well-formed cases, 7 extended lc above limit (or 65535), 8 noise, 9 one byte off
    function automatic byte_q_t make_frame(int kind, int limit);
        byte_q_t q;
        int      lc;
        int      hi;
        q = header4();
        case (kind)
            1: q.push_back(le_byte());
            2, 3:
            begin
                lc = ($urandom_range(15) == 0) ? $urandom_range(255, 1)
                                               : $urandom_range(12, 1);
                q.push_back(8'(lc));
                repeat (lc) q.push_back(8'($urandom));
                if (kind == 3) q.push_back(le_byte());
            end
            4:
            begin
                q.push_back(8'h00);
                q.push_back(le_byte());
                q.push_back(le_byte());
            end
            5, 6:
            begin
                hi = (limit < 1) ? 8 : ((limit < 24) ? limit : 24);
                if ($urandom_range(24) == 0 && limit > 24) hi = (limit < 300) ? limit : 300;
                lc = $urandom_range(hi, 1);
                q.push_back(8'h00);
                q.push_back(8'(lc >> 8));
                q.push_back(8'(lc));
                repeat (lc) q.push_back(8'($urandom));
                if (kind == 6)
                begin
                    q.push_back(le_byte());
                    q.push_back(le_byte());
                end
            end
            7:
            begin
                lc = (limit >= 65535) ? 65535 : $urandom_range(65535, limit + 1);
                q.push_back(8'h00);
                q.push_back(8'(lc >> 8));
                q.push_back(8'(lc));
                repeat ($urandom_range(3)) q.push_back(8'($urandom));
            end
            8:
            begin
                q.delete();
                repeat ($urandom_range(10, 1)) q.push_back(8'($urandom));
            end
            9:
            begin
                q = make_frame($urandom_range(6, 1), limit);
                if ($urandom_range(1) && q.size() > 4) void'(q.pop_back());
                else q.push_back(8'($urandom));
            end
            default: ;
        endcase
        return q;
    endfunction

    task automatic run_phase(logic [15:0] limit, int sender_idle, int receiver_stall);
        int      sent;
        byte_q_t f;
        write_limit(limit);
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            f = make_frame($urandom_range(9), int'(limit));
            send_frame(f);
            sent += f.size();
        end
        drain();
    endtask

    initial
    begin
        byte_q_t f;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // too short, class byte variants, short and extended cases
        f = '{8'h00};
        send_frame(f);
        f = '{8'h80, 8'hCA, 8'h9F};
        send_frame(f);
        f = '{8'h00, 8'hA4, 8'h04, 8'h00};
        send_frame(f);
        f = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(f);
        f = '{8'hE0, 8'h01, 8'h02, 8'h03};
        send_frame(f);
        f = '{8'h10, 8'h20, 8'h00, 8'h00};
        send_frame(f);
        f = '{8'h0C, 8'h84, 8'h00, 8'h00};
        send_frame(f);
        f = '{8'h03, 8'hB0, 8'h00, 8'h00, 8'h00};
        send_frame(f);
        f = '{8'h01, 8'hB0, 8'h7F, 8'h80, 8'hFF};
        send_frame(f);
        f = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h01, 8'hAA};
        send_frame(f);
        f = '{8'h00, 8'h88, 8'h00, 8'h00, 8'h02, 8'h11, 8'h22, 8'h00};
        send_frame(f);
        f = '{8'h00, 8'hA4, 8'h00, 8'h00, 8'h00, 8'h55};
        send_frame(f);
        f = '{8'h00, 8'hA4, 8'h00, 8'h00, 8'h03, 8'h01, 8'h02};
        send_frame(f);
        f = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_frame(f);
        f = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
        send_frame(f);
        f = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'hAB, 8'hCD};
        send_frame(f);
        f = '{8'h00, 8'h2A, 8'h80, 8'h86, 8'h00, 8'h00, 8'h01, 8'h5A, 8'h00, 8'h00};
        send_frame(f);
        f = '{8'h00, 8'h2A, 8'h80, 8'h86, 8'h00, 8'h00, 8'h01, 8'h5A, 8'h12, 8'h34};
        send_frame(f);
        f = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h11};
        send_frame(f);
        f = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h04, 8'h01, 8'h11};
        send_frame(f);
        f = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02, 8'h11};
        send_frame(f);
        f = '{8'h00, 8'hDA, 8'h01, 8'h02, 8'hFF};
        repeat (255) f.push_back(8'($urandom));
        send_frame(f);
        drain();

        // zero limit: every extended Lc is rejected
        write_limit(16'h0000);
        f = '{8'h00, 8'hD6, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h77};
        send_frame(f);
        f = '{8'h00, 8'hB0, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34};
        send_frame(f);
        drain();

        run_phase(16'd1, 0, 0);
        run_phase(16'($urandom_range(200, 2)), 61, 0);
        run_phase(16'hFFFF, 0, 61);
        run_phase(apdu_pkg::EXT_DATA_MAX_RST, 6, 6);

        if (sb.failures == 0 && sb.frame_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
